>>> hw/rtl/dvrt_pkg.sv
// dvrt_pkg: shared types and constants for the distance-vector route table
// used by distance_vector_route_table and dvrt_entry_alu; no dependencies
package dvrt_pkg;

    localparam int NODES_DEF = 256;

    localparam logic [15:0] COST_UNREACH = 16'hFFFF;
    localparam logic [7:0]  AGE_SAT      = 8'hFF;
    localparam logic [8:0]  COUNT_SAT    = 9'd511;

    // register indexes on the configuration port
    localparam logic REG_OWN_ID  = 1'b0;
    localparam logic REG_MAX_AGE = 1'b1;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_SWEEP  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // one table entry as held in memory
    typedef struct packed {
        logic        valid;
        logic [15:0] cost;
        logic [7:0]  hop;
        logic [7:0]  age;
    } t_entry;

    // per-item controls handed to the entry update logic
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  dest;
        logic [7:0]  hop;
        logic [15:0] new_cost;
        logic [15:0] old_cost;
        logic [7:0]  own_id;
        logic [7:0]  max_age;
    } t_ctl;

endpackage

>>> hw/rtl/dvrt_entry_alu.sv
// dvrt_entry_alu: read-modify-write logic applied to one table entry per cycle
// depends on dvrt_pkg (t_entry, t_ctl, command codes)
module dvrt_entry_alu
    import dvrt_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  t_ctl                         i_ctl,
    input  logic [$clog2(NODES)-1:0]     i_idx,
    input  t_entry                       i_ent,
    output t_entry                       o_ent,
    output logic                         o_chg
);

    logic   is_dest;
    logic   is_own;
    logic   ins;
    t_entry ins_ent;

    assign is_dest = (32'(i_idx) == 32'(i_ctl.dest));
    assign is_own  = (32'(i_idx) == 32'(i_ctl.own_id));

    // insert or replace decision for the addressed entry
    always_comb begin
        ins = 1'b0;
        if (is_dest) begin
            if (!i_ent.valid) begin
                ins = 1'b1;
            end else if (i_ent.hop != i_ctl.hop && i_ctl.new_cost < i_ent.cost) begin
                ins = 1'b1;
            end
        end
        ins_ent = i_ent;
        if (ins) begin
            ins_ent.valid = 1'b1;
            ins_ent.cost  = i_ctl.new_cost;
            ins_ent.hop   = i_ctl.hop;
            ins_ent.age   = '0;
        end
    end

    // per-command entry modification
    always_comb begin
        o_ent = i_ent;
        o_chg = 1'b0;
        case (i_ctl.cmd)
            CMD_UPDATE: begin
                if (i_ctl.new_cost == COST_UNREACH) begin
                    // withdraw every route through the dead neighbor
                    if (i_ent.valid && i_ent.hop == i_ctl.dest) begin
                        o_ent.valid = 1'b0;
                        o_chg       = 1'b1;
                    end
                end else begin
                    o_ent = ins_ent;
                    o_chg = ins;
                    // shift cost and refresh age of routes through the advertising neighbor
                    if (ins_ent.valid && ins_ent.hop == i_ctl.hop) begin
                        o_ent.cost = ins_ent.cost + i_ctl.new_cost - i_ctl.old_cost;
                        o_ent.age  = '0;
                        if (i_ctl.new_cost != i_ctl.old_cost) begin
                            o_chg = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (i_ent.valid && i_ent.age != AGE_SAT) begin
                    o_ent.age = i_ent.age + 8'd1;
                end
            end
            CMD_SWEEP: begin
                if (i_ent.valid && i_ent.age > i_ctl.max_age) begin
                    o_chg = 1'b1;
                    if (!is_own) begin
                        o_ent.valid = 1'b0;
                    end
                end
            end
            default: begin
                o_ent = i_ent;
            end
        endcase
    end

endmodule

>>> hw/rtl/distance_vector_route_table.sv
// distance_vector_route_table: direct-indexed distance-vector forwarding table
// depends on dvrt_pkg and dvrt_entry_alu
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------
//  in        | i_in_valid / o_in_ready   | command, dest_id, next_hop, costs
//  out       | o_out_valid / i_out_ready | changed, entry_count, entry fields
//  config    | psel/penable/pwrite/pready| paddr, pwdata, prdata (APB style)
//
// every item walks all NODES table entries through one memory: a read each
// cycle, modify and write back in the following cycle; the result goes to the
// output register and the next item is taken once the pass has loaded it
// there. after reset a clearing pass zeroes the
// valid bits; no input is taken until it ends. a new item is taken while a
// result waits; a finished pass holds its result while the output stalls.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_dest_id,
    input  logic [7:0]  i_next_hop,
    input  logic [15:0] i_new_cost,
    input  logic [15:0] i_old_cost,
    // result item
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_changed,
    output logic [8:0]  o_entry_count,
    output logic        o_entry_valid,
    output logic [15:0] o_entry_cost,
    output logic [7:0]  o_entry_hop,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    // configuration registers
    logic [7:0] r_own_id;
    logic [7:0] r_max_age;

    // control
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_p1_vld, n_p1_vld;
    logic [IW-1:0]  r_p1_idx;
    logic           rd_en;
    logic           last_wb;
    logic           out_load;

    // item and pass accumulators
    t_ctl           r_ctl;
    t_ctl           ctl;
    logic           r_chg;
    logic [CW-1:0]  r_count;
    logic           r_hit_valid;
    logic [15:0]    r_hit_cost;
    logic [7:0]     r_hit_hop;

    // table memory
    t_entry         mem [NODES];
    t_entry         r_mem_q;
    t_entry         alu_ent;
    logic           alu_chg;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    t_entry         wr_data;

    // output register
    logic           r_out_valid;
    logic           r_out_changed;
    logic [8:0]     r_out_count;
    logic           r_out_evalid;
    logic [15:0]    r_out_cost;
    logic [7:0]     r_out_hop;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= '0;
            r_max_age <= 8'd5;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_OWN_ID:  r_own_id  <= pwdata[7:0];
                REG_MAX_AGE: r_max_age <= pwdata[7:0];
                default:     r_own_id  <= r_own_id;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OWN_ID:  prdata = {24'd0, r_own_id};
            REG_MAX_AGE: prdata = {24'd0, r_max_age};
            default:     prdata = '0;
        endcase
    end

    // controls seen by the entry logic, config taken live (user keeps it static while busy; not enforced)
    always_comb begin
        ctl         = r_ctl;
        ctl.own_id  = r_own_id;
        ctl.max_age = r_max_age;
    end

    dvrt_entry_alu #(
        .NODES (NODES)
    ) u_alu (
        .i_ctl (ctl),
        .i_idx (r_p1_idx),
        .i_ent (r_mem_q),
        .o_ent (alu_ent),
        .o_chg (alu_chg)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign rd_en      = (r_state == ST_RUN) && (32'(r_cnt) < NODES);
    assign last_wb    = r_p1_vld && (32'(r_p1_idx) == NODES - 1);
    assign out_load   = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_p1_vld = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (32'(r_cnt) == NODES - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_p1_vld = rd_en;
                if (rd_en) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (last_wb) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_p1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_p1_vld <= n_p1_vld;
        end
    end

    // memory write port: clearing pass or write-back of the modified entry
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_p1_idx;
        wr_data = alu_ent;
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[IW-1:0];
            wr_data = '0;
        end else if (r_p1_vld) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[r_cnt[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_p1_idx <= r_cnt[IW-1:0];
        end
    end

    // item capture and pass accumulation
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ctl.cmd      <= t_cmd'(i_command);
            r_ctl.dest     <= i_dest_id;
            r_ctl.hop      <= i_next_hop;
            r_ctl.new_cost <= i_new_cost;
            r_ctl.old_cost <= i_old_cost;
            r_ctl.own_id   <= '0;
            r_ctl.max_age  <= '0;
            r_chg          <= 1'b0;
            r_count        <= '0;
            r_hit_valid    <= 1'b0;
            r_hit_cost     <= '0;
            r_hit_hop      <= '0;
        end else if (r_p1_vld) begin
            r_chg   <= r_chg | alu_chg;
            r_count <= r_count + CW'(alu_ent.valid);
            if (32'(r_p1_idx) == 32'(r_ctl.dest)) begin
                r_hit_valid <= alu_ent.valid;
                r_hit_cost  <= alu_ent.valid ? alu_ent.cost : 16'd0;
                r_hit_hop   <= alu_ent.valid ? alu_ent.hop : 8'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_changed <= r_chg;
            r_out_count   <= (32'(r_count) > 32'(COUNT_SAT)) ? COUNT_SAT : 9'(r_count);
            r_out_evalid  <= r_hit_valid;
            r_out_cost    <= r_hit_cost;
            r_out_hop     <= r_hit_hop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_changed     = r_out_changed;
    assign o_entry_count = r_out_count;
    assign o_entry_valid = r_out_evalid;
    assign o_entry_cost  = r_out_cost;
    assign o_entry_hop   = r_out_hop;

endmodule

>>> hw/rtl/dvrt_chk.sv
// dvrt_chk: port-level checks for distance_vector_route_table, bound to the top
// depends on the top level's port list only
module dvrt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_changed,
    input logic [8:0]  o_entry_count,
    input logic        o_entry_valid,
    input logic [15:0] o_entry_cost,
    input logic [7:0]  o_entry_hop
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entry_count)
            && $stable(o_entry_cost) && $stable(o_entry_hop) && $stable(o_changed))
        else $error("result changed while stalled");

    // a missing entry reports zero cost and hop
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_entry_cost == 16'd0 && o_entry_hop == 8'd0)
        else $error("missing entry with nonzero fields");

    // a present entry is counted
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_valid |-> o_entry_count != 9'd0)
        else $error("entry present but count is zero");

    // clearing pass blocks input right after reset
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("ready during clearing pass");

endmodule

bind distance_vector_route_table dvrt_chk u_dvrt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_changed     (o_changed),
    .o_entry_count (o_entry_count),
    .o_entry_valid (o_entry_valid),
    .o_entry_cost  (o_entry_cost),
    .o_entry_hop   (o_entry_hop)
);

>>> test/tb_distance_vector_route_table.sv
// tb_distance_vector_route_table: self-checking bench for the distance-vector route table
// depends on dvrt_pkg and distance_vector_route_table; predicts reports from a table copy
module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES        = NODES_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam logic [2:0] ADDR_OWN_ID  = {REG_OWN_ID, 2'b00};
    localparam logic [2:0] ADDR_MAX_AGE = {REG_MAX_AGE, 2'b00};

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  dest;
        logic [7:0]  hop;
        logic [15:0] new_cost;
        logic [15:0] old_cost;
    } t_advert;

    typedef struct packed {
        logic        changed;
        logic [8:0]  count;
        logic        valid;
        logic [15:0] cost;
        logic [7:0]  hop;
    } t_route_report;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command     = CMD_NOP;
    logic [7:0]  i_dest_id     = '0;
    logic [7:0]  i_next_hop    = '0;
    logic [15:0] i_new_cost    = '0;
    logic [15:0] i_old_cost    = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic        o_changed;
    logic [8:0]  o_entry_count;
    logic        o_entry_valid;
    logic [15:0] o_entry_cost;
    logic [7:0]  o_entry_hop;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    distance_vector_route_table #(.NODES(NODES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_dest_id     (i_dest_id),
        .i_next_hop    (i_next_hop),
        .i_new_cost    (i_new_cost),
        .i_old_cost    (i_old_cost),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_changed     (o_changed),
        .o_entry_count (o_entry_count),
        .o_entry_valid (o_entry_valid),
        .o_entry_cost  (o_entry_cost),
        .o_entry_hop   (o_entry_hop),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the forwarding table and its registers
    logic        tbl_valid [NODES];
    logic [15:0] tbl_cost  [NODES];
    logic [7:0]  tbl_hop   [NODES];
    logic [7:0]  tbl_age   [NODES];
    logic [7:0]  own_id    = 8'd0;
    logic [7:0]  age_limit = 8'd5;

    t_advert       advert_q [$];
    t_route_report report_q [$];
    int n_items   = 0;
    int n_reports = 0;
    int n_errors  = 0;
    int quiet     = 0;
    bit in_xfer   = 1'b0;
    bit out_xfer  = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    always #6 i_clk = ~i_clk;

    // next state of the table for one accepted item, and the report it yields
    function automatic t_route_report route_table_step(t_advert it);
        t_route_report r;
        logic chg;
        int n;
        chg = 1'b0;
        n = 0;
        case (it.cmd)
            CMD_UPDATE: begin
                if (it.new_cost == COST_UNREACH) begin
                    // withdraw everything routed through the dead neighbor
                    for (int k = 0; k < NODES; k++) begin
                        if (tbl_valid[k] && tbl_hop[k] == it.dest) begin
                            tbl_valid[k] = 1'b0;
                            chg = 1'b1;
                        end
                    end
                end else begin
                    // insert a missing route or take a cheaper one via another hop
                    if (!tbl_valid[it.dest] || (tbl_hop[it.dest] != it.hop &&
                                                it.new_cost < tbl_cost[it.dest])) begin
                        tbl_valid[it.dest] = 1'b1;
                        tbl_cost[it.dest]  = it.new_cost;
                        tbl_hop[it.dest]   = it.hop;
                        tbl_age[it.dest]   = 8'd0;
                        chg = 1'b1;
                    end
                    // shift and refresh all routes through the advertiser
                    for (int k = 0; k < NODES; k++) begin
                        if (tbl_valid[k] && tbl_hop[k] == it.hop) begin
                            tbl_cost[k] = tbl_cost[k] + it.new_cost - it.old_cost;
                            tbl_age[k]  = 8'd0;
                            if (it.new_cost != it.old_cost) chg = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                for (int k = 0; k < NODES; k++) begin
                    if (tbl_valid[k] && tbl_age[k] != AGE_SAT) tbl_age[k] = tbl_age[k] + 8'd1;
                end
            end
            CMD_SWEEP: begin
                for (int k = 0; k < NODES; k++) begin
                    if (tbl_valid[k] && tbl_age[k] > age_limit) begin
                        chg = 1'b1;
                        if (k != int'(own_id)) tbl_valid[k] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < NODES; k++) begin
            if (tbl_valid[k]) n++;
        end
        r.changed = chg;
        r.count   = (n > int'(COUNT_SAT)) ? COUNT_SAT : 9'(n);
        r.valid   = tbl_valid[it.dest];
        r.cost    = tbl_valid[it.dest] ? tbl_cost[it.dest] : 16'd0;
        r.hop     = tbl_valid[it.dest] ? tbl_hop[it.dest] : 8'd0;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ids picked from the first n of a small shared pool so routes collide
    function automatic logic [7:0] pool_id(int n);
        case ($urandom_range(0, n - 1))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'h21;
            4: return 8'hFF;
            5: return 8'h5A;
            6: return 8'h03;
            7: return 8'h80;
            8: return 8'hC3;
            default: return 8'hFE;
        endcase
    endfunction

    function automatic t_advert make_item(t_cmd cmd, logic [7:0] dest, logic [7:0] hop,
                                          logic [15:0] nc, logic [15:0] oc);
        t_advert it;
        it.cmd      = cmd;
        it.dest     = dest;
        it.hop      = hop;
        it.new_cost = nc;
        it.old_cost = oc;
        return it;
    endfunction

    function automatic t_advert random_item();
        t_advert it;
        int r;
        r = $urandom_range(0, 99);
        it.cmd      = (r < 60) ? CMD_UPDATE : (r < 80) ? CMD_TICK : (r < 97) ? CMD_SWEEP : CMD_NOP;
        it.dest     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : pool_id(10);
        it.hop      = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : pool_id(6);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            it.new_cost = COST_UNREACH;
            it.dest     = pool_id(6);
        end else if (r < 60) begin
            it.new_cost = 16'($urandom_range(0, 200));
        end else begin
            it.new_cost = 16'($urandom_range(0, 65534));
        end
        r = $urandom_range(0, 99);
        if (r < 45)      it.old_cost = it.new_cost;
        else if (r < 80) it.old_cost = 16'($urandom_range(0, 200));
        else             it.old_cost = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // monitor: check reports, track register writes, predict accepted items
    always @(posedge i_clk) begin : monitor
        t_advert it;
        t_route_report want;
        in_xfer  = i_rst_n && i_in_valid && o_in_ready;
        out_xfer = i_rst_n && o_out_valid && i_out_ready;
        if (out_xfer) begin
            n_reports++;
            if (report_q.size() == 0) begin
                $error("report transfer with no item outstanding");
                n_errors++;
            end else begin
                want = report_q.pop_front();
                check_field("changed", want.changed, o_changed);
                check_field("entry_count", want.count, o_entry_count);
                check_field("entry_valid", want.valid, o_entry_valid);
                check_field("entry_cost", want.cost, o_entry_cost);
                check_field("entry_hop", want.hop, o_entry_hop);
            end
        end
        if (i_rst_n && psel && penable && pwrite && pready) begin
            case (paddr)
                ADDR_OWN_ID:  own_id    = pwdata[7:0];
                ADDR_MAX_AGE: age_limit = pwdata[7:0];
                default: ;
            endcase
        end
        if (in_xfer) begin
            it = make_item(t_cmd'(i_command), i_dest_id, i_next_hop, i_new_cost, i_old_cost);
            want = route_table_step(it);
            report_q = {report_q, want};
        end
        // watchdog on cycles without any transfer
        if (in_xfer || out_xfer) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver: presents queued items with random gaps between transfers
    always @(negedge i_clk) begin : feeder
        t_advert nxt;
        if (i_rst_n && !(i_in_valid && !in_xfer)) begin
            if (in_xfer) begin
                if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : idle_cycles();
            end
            if (send_gap > 0 || advert_q.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_in_valid <= 1'b0;
            end else begin
                nxt = advert_q.pop_front();
                i_in_valid <= 1'b1;
                i_command  <= nxt.cmd;
                i_dest_id  <= nxt.dest;
                i_next_hop <= nxt.hop;
                i_new_cost <= nxt.new_cost;
                i_old_cost <= nxt.old_cost;
            end
        end
    end

    // report side stalls, after transfers and now and then at random
    always @(negedge i_clk) begin : sink
        if (out_xfer) begin
            if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
            recv_gap = recv_calm ? 0 : idle_cycles();
        end else if (!recv_calm && recv_gap == 0 && $urandom_range(0, 99) < 2) begin
            recv_gap = idle_cycles();
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_item(t_advert it);
        advert_q = {advert_q, it};
        n_items++;
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) queue_item(random_item());
    endtask

    task automatic wait_reports();
        while (n_reports < n_items) @(negedge i_clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] addr, logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        for (int k = 0; k < NODES; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_cost[k]  = '0;
            tbl_hop[k]   = '0;
            tbl_age[k]   = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: inserts, wraps, replacement, withdrawal, aging, own-id sweep
        queue_item(make_item(CMD_UPDATE, 8'h00, 8'h00, 16'd0, 16'd0));
        queue_item(make_item(CMD_UPDATE, 8'hFF, 8'hFF, 16'hFFFE, 16'd0));
        queue_item(make_item(CMD_UPDATE, 8'd10, 8'd1, 16'd100, 16'd100));
        queue_item(make_item(CMD_UPDATE, 8'd11, 8'd1, 16'd50, 16'd40));
        queue_item(make_item(CMD_UPDATE, 8'd10, 8'd2, 16'd200, 16'd200));
        queue_item(make_item(CMD_UPDATE, 8'd10, 8'd2, 16'd5, 16'd5));
        queue_item(make_item(CMD_UPDATE, 8'd11, 8'd1, 16'd30, 16'd0));
        queue_item(make_item(CMD_UPDATE, 8'd20, 8'd1, 16'd0, 16'hFFFF));
        queue_item(make_item(CMD_TICK, 8'd10, 8'd0, 16'd0, 16'd0));
        queue_item(make_item(CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        queue_item(make_item(CMD_SWEEP, 8'd10, 8'd0, 16'd0, 16'd0));
        queue_item(make_item(CMD_UPDATE, 8'd1, 8'd1, COST_UNREACH, 16'd7));
        queue_item(make_item(CMD_UPDATE, 8'd1, 8'd3, COST_UNREACH, 16'd0));
        queue_item(make_item(CMD_NOP, 8'hFF, 8'hAA, 16'h5555, 16'hAAAA));
        for (int k = 0; k < 5; k++) queue_item(make_item(CMD_TICK, 8'h00, 8'h00, 16'd0, 16'd0));
        queue_item(make_item(CMD_SWEEP, 8'h00, 8'h00, 16'd0, 16'd0));
        queue_item(make_item(CMD_SWEEP, 8'hFF, 8'h00, 16'd0, 16'd0));
        wait_reports();

        write_reg(ADDR_OWN_ID, 8'h5A);
        write_reg(ADDR_MAX_AGE, 8'd5);
        queue_random(40);
        wait_reports();

        // every aged route but the own id's expires on the next sweep
        write_reg(ADDR_OWN_ID, 8'h00);
        write_reg(ADDR_MAX_AGE, 8'd0);
        queue_random(30);
        wait_reports();

        // age saturation: long run of ticks with nothing refreshed
        write_reg(ADDR_OWN_ID, 8'hFF);
        write_reg(ADDR_MAX_AGE, 8'd255);
        queue_item(make_item(CMD_UPDATE, 8'hFF, 8'h07, 16'd10, 16'd10));
        queue_item(make_item(CMD_UPDATE, 8'h21, 8'h09, 16'd300, 16'd300));
        queue_item(make_item(CMD_UPDATE, 8'h80, 8'h09, 16'hFFFE, 16'hFFFE));
        for (int k = 0; k < 258; k++) begin
            queue_item(make_item(CMD_TICK, (k % 2) ? 8'hFF : 8'h21, 8'h00, 16'd0, 16'd0));
            if (k % 64 == 63) queue_item(make_item(CMD_SWEEP, 8'h80, 8'h00, 16'd0, 16'd0));
        end
        queue_item(make_item(CMD_SWEEP, 8'hFF, 8'h00, 16'd0, 16'd0));
        wait_reports();

        // saturated routes now expire, own id is kept
        write_reg(ADDR_MAX_AGE, 8'd254);
        queue_item(make_item(CMD_SWEEP, 8'hFF, 8'h00, 16'd0, 16'd0));
        queue_random(20);
        wait_reports();

        write_reg(ADDR_OWN_ID, 8'h21);
        write_reg(ADDR_MAX_AGE, 8'd2);
        queue_random(20);
        wait_reports();

        repeat (NODES + 16) @(negedge i_clk);
        if (report_q.size() != 0) begin
            $error("%0d expected reports never arrived", report_q.size());
            n_errors++;
        end
        if (n_errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
